// ----- hdl/motor_current_scaler_calc_unit_defines.svh -----
// assertion helpers for the current scaler block
`ifndef MOTOR_CURRENT_SCALER_CALC_UNIT_DEFINES_SVH
`define MOTOR_CURRENT_SCALER_CALC_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, constants, types and lookup functions of the current scaler.
// ----------------------------------------------------------------------------
package mcs_pkg;

   localparam int unsigned CUR_W     = 16;
   localparam int unsigned CFG_W     = 4;
   localparam int unsigned IDX_W     = 2;
   localparam int unsigned SENSE_W   = 10;
   localparam int unsigned PROD1_W   = 24;
   localparam int unsigned NUM_W     = 24;
   localparam int unsigned DEN_W     = 22;
   localparam int unsigned CMP_W     = 32;
   localparam int unsigned CS_W      = 5;
   localparam int unsigned SCALER_W  = 8;
   localparam int unsigned HOLD_W    = 5;
   localparam int unsigned CNT_W     = 3;

   localparam logic [13:0]       SCALE_NUM  = 14'd11585;
   localparam logic [16:0]       DIV_UNIT   = 17'd83198;
   localparam logic [CS_W-1:0]   CS_TOP     = 5'd31;
   localparam logic [CS_W-1:0]   CS_LOW     = 5'd16;
   localparam logic [CS_W-1:0]   CS_FAIL    = 5'd15;
   localparam logic [CNT_W-1:0]  DIV_FIRST  = 3'd7;

   localparam logic [IDX_W-1:0] CSR_SENSE_LEVEL = 2'd0;
   localparam logic [IDX_W-1:0] CSR_HOLD_RATIO  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_SELF_LOCK   = 2'd2;

   localparam logic [CFG_W-1:0] RST_SENSE_LEVEL = 4'd6;
   localparam logic [CFG_W-1:0] RST_HOLD_RATIO  = 4'd10;

   typedef struct packed {
      logic [CFG_W-1:0] sense_level;
      logic [CFG_W-1:0] hold_ratio;
      logic             self_lock;
   } cfg_type;

   typedef struct packed {
      logic load;       // capture request current
      logic mul_sense;  // 11585 * sense
      logic mul_cur;    // times current, wrap and shift
      logic srch_step;  // test one run scale
      logic div_step;   // one quotient bit
      logic out_load;   // update result registers
   } cmd_type;

   typedef struct packed {
      logic srch_stop;
      logic div_last;
   } sts_type;

   // level * 65535 / 1000
   function automatic logic [SENSE_W-1:0] sense_of(input logic [CFG_W-1:0] level);
      logic [SENSE_W-1:0] s;
      case (level)
         4'd0:    s = 10'd0;
         4'd1:    s = 10'd65;
         4'd2:    s = 10'd131;
         4'd3:    s = 10'd196;
         4'd4:    s = 10'd262;
         4'd5:    s = 10'd327;
         4'd6:    s = 10'd393;
         4'd7:    s = 10'd458;
         4'd8:    s = 10'd524;
         4'd9:    s = 10'd589;
         4'd10:   s = 10'd655;
         4'd11:   s = 10'd720;
         4'd12:   s = 10'd786;
         4'd13:   s = 10'd851;
         4'd14:   s = 10'd917;
         default: s = 10'd983;
      endcase
      return s;
   endfunction

   // 83198 * (cs + 1)
   function automatic logic [DEN_W-1:0] denom_of(input logic [CS_W-1:0] cs);
      logic [5:0]       n;
      logic [DEN_W-1:0] d;
      n = {1'b0, cs} + 6'd1;
      d = {5'b0, DIV_UNIT} * {16'b0, n};
      return d;
   endfunction

   // cs * ratio / 100, product stays below 500
   function automatic logic [HOLD_W-1:0] hold_of(input logic [CS_W-1:0] cs,
                                                 input logic [CFG_W-1:0] ratio);
      logic [8:0]        p;
      logic [HOLD_W-1:0] h;
      p = {4'b0, cs} * {5'b0, ratio};
      if (p >= 9'd400)      h = 5'd4;
      else if (p >= 9'd300) h = 5'd3;
      else if (p >= 9'd200) h = 5'd2;
      else if (p >= 9'd100) h = 5'd1;
      else                  h = 5'd0;
      return h;
   endfunction

endpackage

// ----- hdl/motor_current_scaler_calc_unit.sv -----
`timescale 1ns / 1ps
// sequence: after the request transfer, the multiply steps in MUL1 and MUL2, the
//   scale tests in SRCH, the quotient bits in DIV and the hand-off in FIN
// throughput: one request at a time, next one taken the cycle after hand-off;
//   the scale search and the bit-serial divider set the figure
// reset: synchronous, clears the sequencer and response valid, loads
//   sense_level 6, hold_ratio 10, self_lock 0
// ----------------------------------------------------------------------------
// motor_current_scaler_calc_unit
// RMS coil current to global scaler, run scale and hold scale.
// ----------------------------------------------------------------------------
`include "motor_current_scaler_calc_unit_defines.svh"

module motor_current_scaler_calc_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mcs_pkg::CUR_W-1:0]      req_current_ma,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mcs_pkg::SCALER_W-1:0]   rsp_scaler,
   output logic [mcs_pkg::CS_W-1:0]       rsp_run_scale,
   output logic [mcs_pkg::HOLD_W-1:0]     rsp_hold_scale,
   input  logic                           csr_wr_en,
   input  logic [mcs_pkg::IDX_W-1:0]      csr_index,
   input  logic [mcs_pkg::CFG_W-1:0]      csr_wdata
);

   mcs_pkg::cfg_type cfg_ff;
   mcs_pkg::cmd_type cmd;
   mcs_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sense_level <= mcs_pkg::RST_SENSE_LEVEL;
         cfg_ff.hold_ratio  <= mcs_pkg::RST_HOLD_RATIO;
         cfg_ff.self_lock   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mcs_pkg::CSR_SENSE_LEVEL: cfg_ff.sense_level <= csr_wdata;
            mcs_pkg::CSR_HOLD_RATIO:  cfg_ff.hold_ratio  <= csr_wdata;
            mcs_pkg::CSR_SELF_LOCK:   cfg_ff.self_lock   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   mcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mcs_datapath u_dp (
      .clock          (clock),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .sts            (sts),
      .req_current_ma (req_current_ma),
      .rsp_scaler     (rsp_scaler),
      .rsp_run_scale  (rsp_run_scale),
      .rsp_hold_scale (rsp_hold_scale)
   );

   // busy right after a request transfer
   `MCS_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready,
      "ready after transfer")
   // fail code always comes with a quotient below the lower bound
   `MCS_ASSERT_IMP(a_fail_scaler, clock, reset,
      rsp_valid && (rsp_run_scale == mcs_pkg::CS_FAIL), rsp_scaler < 8'd32,
      "fail code with large scaler")
   // run scale never under the fail code
   `MCS_ASSERT_IMP(a_run_range, clock, reset, rsp_valid,
      rsp_run_scale >= mcs_pkg::CS_FAIL, "run scale out of range")
   // hold scale bounded by 31*15/100
   `MCS_ASSERT_IMP(a_hold_range, clock, reset, rsp_valid, rsp_hold_scale <= 5'd4,
      "hold scale out of range")

endmodule

// ----- hdl/mcs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer: multiply, scale search, quotient bits, result hand-off.
// ----------------------------------------------------------------------------
module mcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mcs_pkg::cmd_type cmd,
   input  mcs_pkg::sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_SRCH = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_sense = 1'b1;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_cur = 1'b1;
            state_in    = ST_SRCH;
         end
         ST_SRCH: begin
            cmd.srch_step = 1'b1;
            if (sts.srch_stop) state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/mcs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_datapath
// Numerator products, run scale search, restoring divider, result registers.
// ----------------------------------------------------------------------------
module mcs_datapath (
   input  logic                           clock,
   input  mcs_pkg::cfg_type               cfg,
   input  mcs_pkg::cmd_type               cmd,
   output mcs_pkg::sts_type               sts,
   input  logic [mcs_pkg::CUR_W-1:0]      req_current_ma,
   output logic [mcs_pkg::SCALER_W-1:0]   rsp_scaler,
   output logic [mcs_pkg::CS_W-1:0]       rsp_run_scale,
   output logic [mcs_pkg::HOLD_W-1:0]     rsp_hold_scale
);

   logic [mcs_pkg::CUR_W-1:0]    cur_ff;
   logic [mcs_pkg::PROD1_W-1:0]  p1_ff;
   logic [mcs_pkg::NUM_W-1:0]    num_ff;
   logic [mcs_pkg::CS_W-1:0]     cs_ff;
   logic [mcs_pkg::DEN_W-1:0]    div_d_ff;
   logic                         ovf_ff;
   logic [mcs_pkg::NUM_W-1:0]    rem_ff;
   logic [mcs_pkg::SCALER_W-1:0] q_ff;
   logic [mcs_pkg::CNT_W-1:0]    cnt_ff;
   logic [mcs_pkg::SCALER_W-1:0] scaler_ff;
   logic [mcs_pkg::CS_W-1:0]     run_ff;
   logic [mcs_pkg::HOLD_W-1:0]   hold_ff;

   logic [39:0]                  prod2;
   logic [mcs_pkg::PROD1_W-1:0]  prod1;
   logic [mcs_pkg::DEN_W-1:0]    den;
   logic [mcs_pkg::CMP_W-1:0]    num_x, lim_hi, lim_lo;
   logic                         over, fit, at_low;
   logic [mcs_pkg::CMP_W-1:0]    rem_x, dsh;
   logic                         take;

   assign prod1 = {10'b0, mcs_pkg::SCALE_NUM} * {14'b0, mcs_pkg::sense_of(cfg.sense_level)};
   assign prod2 = {16'b0, p1_ff} * {24'b0, cur_ff};

   // quotient above 255 iff num >= 256*d, at least 32 iff num >= 32*d
   assign den    = mcs_pkg::denom_of(cs_ff);
   assign num_x  = {8'b0, num_ff};
   assign lim_hi = {2'b0, den, 8'b0};
   assign lim_lo = {5'b0, den, 5'b0};
   assign over   = num_x >= lim_hi;
   assign fit    = num_x >= lim_lo;
   assign at_low = (cs_ff == mcs_pkg::CS_LOW);

   assign rem_x = {8'b0, rem_ff};
   assign dsh   = {10'b0, div_d_ff} << cnt_ff;
   assign take  = rem_x >= dsh;

   assign sts.srch_stop = over || fit || at_low;
   assign sts.div_last  = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) cur_ff <= req_current_ma;
      if (cmd.mul_sense) p1_ff <= prod1;
      if (cmd.mul_cur) begin
         num_ff <= prod2[31:8];
         cs_ff  <= mcs_pkg::CS_TOP;
         ovf_ff <= 1'b0;
      end
      if (cmd.srch_step) begin
         div_d_ff <= den;
         rem_ff   <= num_ff;
         q_ff     <= '0;
         cnt_ff   <= mcs_pkg::DIV_FIRST;
         if (over) begin
            ovf_ff <= 1'b1;
         end else if (!fit) begin
            // no fit at the lowest scale leaves the fail code
            if (at_low) cs_ff <= mcs_pkg::CS_FAIL;
            else        cs_ff <= cs_ff - 5'd1;
         end
      end
      if (cmd.div_step) begin
         q_ff   <= {q_ff[mcs_pkg::SCALER_W-2:0], take};
         cnt_ff <= cnt_ff - 3'd1;
         if (take) rem_ff <= rem_ff - dsh[mcs_pkg::NUM_W-1:0];
      end
      if (cmd.out_load) begin
         scaler_ff <= ovf_ff ? '0 : q_ff;
         run_ff    <= cs_ff;
         hold_ff   <= cfg.self_lock ? '0 : mcs_pkg::hold_of(cs_ff, cfg.hold_ratio);
      end
   end

   assign rsp_scaler     = scaler_ff;
   assign rsp_run_scale  = run_ff;
   assign rsp_hold_scale = hold_ff;

endmodule

// ----- tb/tb_motor_current_scaler_calc_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_current_scaler_calc_unit
// Drives coil current requests through the scaler with random gaps on both
// handshakes, checks every response against a table value or a local computation
// of the scaler, run scale and hold scale. Covers several register settings,
// including the extremes, with a directed table followed by random traffic.
// ----------------------------------------------------------------------------
module tb_motor_current_scaler_calc_unit;

   localparam int unsigned CLK_HALF     = 5;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned TAIL_CYCLES  = 40;
   localparam int unsigned IDLE_PCT     = 17;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 150;
   localparam int unsigned SMALL_CUR    = 2000;

   localparam logic [31:0] SENSE_FULL   = 32'd65535;
   localparam logic [31:0] SENSE_DIV    = 32'd1000;
   localparam logic [31:0] SCALER_LO    = 32'd32;
   localparam logic [31:0] SCALER_HI    = 32'd255;
   localparam logic [31:0] HOLD_DIV     = 32'd100;

   // index with no register behind it, writes must be ignored
   localparam logic [mcs_pkg::IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [mcs_pkg::SCALER_W-1:0] scaler;
      logic [mcs_pkg::CS_W-1:0]     run;
      logic [mcs_pkg::HOLD_W-1:0]   hold;
   } scaling_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic [mcs_pkg::IDX_W-1:0]    idx;
      logic [mcs_pkg::CFG_W-1:0]    data;
      logic [mcs_pkg::CUR_W-1:0]    cur;
      bit                           typed;
      logic [mcs_pkg::SCALER_W-1:0] scaler;
      logic [mcs_pkg::CS_W-1:0]     run;
      logic [mcs_pkg::HOLD_W-1:0]   hold;
   } row_type;

   localparam int DIR_N = 29;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [mcs_pkg::CUR_W-1:0]     req_current_ma;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [mcs_pkg::SCALER_W-1:0]  rsp_scaler;
   logic [mcs_pkg::CS_W-1:0]      rsp_run_scale;
   logic [mcs_pkg::HOLD_W-1:0]    rsp_hold_scale;
   logic                          csr_wr_en;
   logic [mcs_pkg::IDX_W-1:0]     csr_index;
   logic [mcs_pkg::CFG_W-1:0]     csr_wdata;

   mcs_pkg::cfg_type              cfg;
   scaling_type                   pending_q[$];
   int unsigned                   errors;
   int unsigned                   cycles;
   bit                            no_idle;

   row_type dir_rows [DIR_N] = '{
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd1},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hFFFF, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd1, 1'b0, 8'd0, 5'd0, 5'd0},
      // last current before the product wraps at the reset level, then the first
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd943, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd944, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'h5555, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hAAAA, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_CSR,  mcs_pkg::CSR_SENSE_LEVEL, 4'd15, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hFFFF, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd1},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd1, 1'b0, 8'd0, 5'd0, 5'd0},
      // zero level zeroes every quotient
      '{ROW_CSR,  mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hFFFF, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd1},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'h1234, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd1},
      '{ROW_CSR,  mcs_pkg::CSR_HOLD_RATIO, 4'd0, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hFFFF, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd0},
      '{ROW_CSR,  mcs_pkg::CSR_HOLD_RATIO, 4'd15, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd2},
      '{ROW_CSR,  mcs_pkg::CSR_SENSE_LEVEL, 4'd15, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_CSR,  mcs_pkg::CSR_SELF_LOCK, 4'd1, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'hFFFF, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd300, 1'b0, 8'd0, 5'd0, 5'd0},
      // only bit 0 of the write data reaches self_lock
      '{ROW_CSR,  mcs_pkg::CSR_SELF_LOCK, 4'hE, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd2},
      '{ROW_CSR,  CSR_UNUSED, 4'hF, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd2},
      '{ROW_CSR,  mcs_pkg::CSR_HOLD_RATIO, 4'd7, 16'd0, 1'b0, 8'd0, 5'd0, 5'd0},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'd0, 1'b1, 8'd0, mcs_pkg::CS_FAIL, 5'd1},
      '{ROW_ITEM, mcs_pkg::CSR_SENSE_LEVEL, 4'd0, 16'h8000, 1'b0, 8'd0, 5'd0, 5'd0}
   };

   motor_current_scaler_calc_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_current_ma (req_current_ma),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scaler     (rsp_scaler),
      .rsp_run_scale  (rsp_run_scale),
      .rsp_hold_scale (rsp_hold_scale),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // scaler search: sense from level, wrapped product, scale walk from the top
   function automatic scaling_type predict_scaling(input logic [mcs_pkg::CUR_W-1:0] cur,
                                                   input mcs_pkg::cfg_type c);
      logic [31:0] sense;
      logic [31:0] num;
      logic [31:0] cs;
      logic [31:0] q;
      logic [31:0] hold;
      bit          done;
      scaling_type r;
      sense = ({28'd0, c.sense_level} * SENSE_FULL) / SENSE_DIV;
      num   = {18'd0, mcs_pkg::SCALE_NUM} * sense;
      num   = num * {16'd0, cur};
      num   = num >> 8;
      cs    = {27'd0, mcs_pkg::CS_TOP};
      q     = 32'd0;
      done  = 1'b0;
      while (!done && cs >= {27'd0, mcs_pkg::CS_LOW}) begin
         q = num / ({15'd0, mcs_pkg::DIV_UNIT} * (cs + 32'd1));
         if (q >= SCALER_LO && q <= SCALER_HI) begin
            done = 1'b1;
         end else if (q < SCALER_LO) begin
            cs = cs - 32'd1;
         end else begin
            // overflow means full scale
            q    = 32'd0;
            done = 1'b1;
         end
      end
      hold = c.self_lock ? 32'd0 : (cs * {28'd0, c.hold_ratio}) / HOLD_DIV;
      r.scaler = q[mcs_pkg::SCALER_W-1:0];
      r.run    = cs[mcs_pkg::CS_W-1:0];
      r.hold   = hold[mcs_pkg::HOLD_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // one request transfer, gap in front of it at random
   task automatic send_item(input logic [mcs_pkg::CUR_W-1:0] cur, input bit typed,
                            input scaling_type typed_exp);
      int gap;
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_current_ma <= cur;
      do @(posedge clock); while (!req_ready);
      pending_q.push_back(typed ? typed_exp : predict_scaling(cur, cfg));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_q.size() != 0);
   endtask

   task automatic write_csr(input logic [mcs_pkg::IDX_W-1:0] idx,
                            input logic [mcs_pkg::CFG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         mcs_pkg::CSR_SENSE_LEVEL: cfg.sense_level = data;
         mcs_pkg::CSR_HOLD_RATIO:  cfg.hold_ratio  = data;
         mcs_pkg::CSR_SELF_LOCK:   cfg.self_lock   = data[0];
         default: ;
      endcase
   endtask

   always @(negedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : check_rsp
      scaling_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: response with none expected, actual scaler %0d run %0d hold %0d",
                     $time, rsp_scaler, rsp_run_scale, rsp_hold_scale);
            errors++;
         end else begin
            want = pending_q.pop_front();
            check_field("scaler", want.scaler, rsp_scaler);
            check_field("run_scale", want.run, rsp_run_scale);
            check_field("hold_scale", want.hold, rsp_hold_scale);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_motor_current_scaler_calc_unit NOT OK");
         $finish;
      end
   end

   initial begin
      scaling_type                typed_exp;
      logic [mcs_pkg::CFG_W-1:0]  lvl;
      logic [mcs_pkg::CFG_W-1:0]  ratio;
      logic [mcs_pkg::CFG_W-1:0]  lock_data;
      logic [mcs_pkg::CUR_W-1:0]  cur;
      logic [31:0]                rnd;
      no_idle        = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_current_ma = '0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cfg            = '{mcs_pkg::RST_SENSE_LEVEL, mcs_pkg::RST_HOLD_RATIO, 1'b0};
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_N; i++) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_csr(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            typed_exp = '{dir_rows[i].scaler, dir_rows[i].run, dir_rows[i].hold};
            send_item(dir_rows[i].cur, dir_rows[i].typed, typed_exp);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // first phases pin the register extremes, the rest are random
         case (ph)
            0: begin
               lvl = 4'd0;  ratio = 4'd15; lock_data = 4'd0;
            end
            1: begin
               lvl = 4'd15; ratio = 4'd0;  lock_data = 4'd1;
            end
            2: begin
               lvl = 4'd15; ratio = 4'd15; lock_data = 4'd0;
            end
            default: begin
               rnd       = $urandom_range(15, 0);
               lvl       = rnd[mcs_pkg::CFG_W-1:0];
               rnd       = $urandom_range(15, 0);
               ratio     = rnd[mcs_pkg::CFG_W-1:0];
               rnd       = $urandom_range(15, 0);
               lock_data = rnd[mcs_pkg::CFG_W-1:0];
            end
         endcase
         drain_results();
         write_csr(mcs_pkg::CSR_SENSE_LEVEL, lvl);
         write_csr(mcs_pkg::CSR_HOLD_RATIO, ratio);
         write_csr(mcs_pkg::CSR_SELF_LOCK, lock_data);
         no_idle = (ph == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 60) rnd = $urandom_range(SMALL_CUR, 0);
            else                         rnd = $urandom_range(16'hFFFF, 0);
            cur = rnd[mcs_pkg::CUR_W-1:0];
            send_item(cur, 1'b0, '0);
         end
      end

      no_idle = 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("tb_motor_current_scaler_calc_unit OK");
      end else begin
         $display("tb_motor_current_scaler_calc_unit NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mcs_pkg.sv
hdl/mcs_ctrl.sv
hdl/mcs_datapath.sv
hdl/motor_current_scaler_calc_unit.sv
tb/tb_motor_current_scaler_calc_unit.sv
